/* hdl/stm_pkg.sv */
// Shared types, constants and codes of the supply and temperature monitor.
`default_nettype none
package stm_pkg;

  // Running average
  localparam int ACC_W     = 16;
  localparam int AVG_SHIFT = 6;
  localparam int AVG_W     = ACC_W - AVG_SHIFT;
  localparam int SAMPLE_W  = 10;

  // Configuration register widths
  localparam int VDD_NUM_W   = 24;
  localparam int INTERCEPT_W = 31;
  localparam int TDIV_W      = 16;
  localparam int TEMP_W      = 16;

  // Result widths
  localparam int SUPPLY_W = 16;
  localparam int RESULT_W = 32;

  // Temperature datapath
  localparam int TEMP_SCALE = 100;
  localparam int PROD_W     = AVG_W + SUPPLY_W;   // savg * supply
  localparam int SCALED_W   = PROD_W + 7;         // times 100
  localparam int DIFF_W     = SCALED_W + 1;       // signed difference

  // Shared divider
  localparam int DIV_W     = SCALED_W;
  localparam int DEN_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // APB
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_VDD_NUMERATOR  = 3'd0,
    REG_TEMP_INTERCEPT = 3'd1,
    REG_TEMP_DIVISOR   = 3'd2,
    REG_TEMP_BASE      = 3'd3,
    REG_TEMP_OFFSET    = 3'd4
  } reg_idx_t;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_REPORT = 1'b1
  } func_t;

  typedef struct packed {
    logic                func;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic                       is_report;
    logic                       next_channel;
    logic [SUPPLY_W-1:0]        supply_hundredths;
    logic signed [RESULT_W-1:0] temperature_hundredths;
    logic                       reference_zero;
  } result_t;

  // Classified work handed from front to back
  typedef struct packed {
    logic             is_report;
    logic             next_channel;
    logic [AVG_W-1:0] ravg;
    logic [AVG_W-1:0] savg;
  } work_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [VDD_NUM_W-1:0]   vdd_numerator;
    logic [INTERCEPT_W-1:0] temp_intercept;
    logic [TDIV_W-1:0]      temp_divisor;
    logic [TEMP_W-1:0]      temp_base;
    logic [TEMP_W-1:0]      temp_offset;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUPPLY,
    B_MUL,
    B_SCALE,
    B_DIFF,
    B_ABS,
    B_TEMP,
    B_DONE
  } back_state_t;

endpackage
`default_nettype wire

/* hdl/supply_and_temperature_monitor_top.sv */
// Top level of the supply and temperature monitor: registers and wiring.
//
// The block takes 10-bit ADC samples that alternate between the internal
// reference (first after reset) and the temperature sensor, keeping a 10-bit
// running average per channel (16-bit accumulator), and on a report beat returns the supply in
// hundredths of a volt (vdd_numerator / reference average, saturated at 65535,
// with reference_zero set when that average is zero) and the temperature in
// hundredths of a degree. Every input beat yields exactly one result beat, in
// order. A sample beat passes through the front, a two-entry queue and the
// back, and a new one may be accepted every cycle while the queue has room.
// A report runs the multiply, scale, difference and absolute-value states
// and the shared restoring divider, one quotient bit per cycle, for the
// supply and the temperature unless the reference average or the divisor is
// zero. The front keeps accepting while the back is busy until the queue
// fills. There is no clearing pass after reset.
// Configuration goes through the APB port (register i at byte 4*i); write it
// only while no beat is in flight.
`default_nettype none
module supply_and_temperature_monitor_top
  import stm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // APB configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  // input beats
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire item_t                 item,
  // result beats
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output result_t                    result
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     wr_en;

  logic     push;
  work_t    push_entry;
  logic     q_full;
  logic     q_valid;
  work_t    q_entry;
  logic     pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // registers: always ready, write on the access phase
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vdd_numerator  <= VDD_NUM_W'(148480);
      cfg.temp_intercept <= INTERCEPT_W'(10752000);
      cfg.temp_divisor   <= TDIV_W'(368);
      cfg.temp_base      <= TEMP_W'(2500);
      cfg.temp_offset    <= TEMP_W'(-500);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VDD_NUMERATOR:  cfg.vdd_numerator  <= pwdata[VDD_NUM_W-1:0];
        REG_TEMP_INTERCEPT: cfg.temp_intercept <= pwdata[INTERCEPT_W-1:0];
        REG_TEMP_DIVISOR:   cfg.temp_divisor   <= pwdata[TDIV_W-1:0];
        REG_TEMP_BASE:      cfg.temp_base      <= pwdata[TEMP_W-1:0];
        REG_TEMP_OFFSET:    cfg.temp_offset    <= pwdata[TEMP_W-1:0];
        default:            ;  // unmapped: ignored
      endcase
    end
  end

  // read back, signed registers sign-extended
  always_comb begin
    unique case (reg_idx)
      REG_VDD_NUMERATOR:  prdata = APB_DATA_W'(cfg.vdd_numerator);
      REG_TEMP_INTERCEPT: prdata = APB_DATA_W'(cfg.temp_intercept);
      REG_TEMP_DIVISOR:   prdata = APB_DATA_W'(cfg.temp_divisor);
      REG_TEMP_BASE:
        prdata = {{(APB_DATA_W-TEMP_W){cfg.temp_base[TEMP_W-1]}}, cfg.temp_base};
      REG_TEMP_OFFSET:
        prdata = {{(APB_DATA_W-TEMP_W){cfg.temp_offset[TEMP_W-1]}}, cfg.temp_offset};
      default:            prdata = '0;
    endcase
  end

  // front: averaging and classification
  stm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .entry      (push_entry)
  );

  // decouples the front from the long report computation
  stm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  // shared serial divider for supply and temperature
  stm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // back: report arithmetic and output register
  stm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .pop          (pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

/* hdl/stm_front.sv */
// Front: accepts items, updates the channel averages, classifies work.
`default_nettype none
module stm_front
  import stm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_ready,
  input  wire item_t item,
  input  wire logic  q_full,
  output logic       push,
  output work_t      entry
);

  logic [ACC_W-1:0] ref_acc;
  logic [ACC_W-1:0] sns_acc;
  logic             conv_ref;
  logic [ACC_W-1:0] sel_acc;
  logic [ACC_W-1:0] acc_next;

  assign item_ready = !q_full;
  assign push       = item_valid && item_ready;

  assign sel_acc  = conv_ref ? ref_acc : sns_acc;
  assign acc_next = sel_acc + {{(ACC_W-SAMPLE_W){1'b0}}, item.sample}
                    - (sel_acc >> AVG_SHIFT);

  always_comb begin
    entry.is_report = (item.func == FUNC_REPORT);
    // after a sample the other channel is selected
    entry.next_channel = (item.func == FUNC_REPORT) ? !conv_ref : conv_ref;
    entry.ravg = ref_acc[ACC_W-1:AVG_SHIFT];
    entry.savg = sns_acc[ACC_W-1:AVG_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_acc  <= '0;
      sns_acc  <= '0;
      conv_ref <= 1'b1;
    end else if (push && item.func == FUNC_SAMPLE) begin
      if (conv_ref) begin
        ref_acc <= acc_next;
      end else begin
        sns_acc <= acc_next;
      end
      conv_ref <= !conv_ref;
    end
  end

endmodule
`default_nettype wire

/* hdl/stm_queue.sv */
// Two-entry queue between front and back.
`default_nettype none
module stm_queue
  import stm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire work_t push_entry,
  output logic       full,
  input  wire logic  pop,
  output logic       q_valid,
  output work_t      q_entry
);

  work_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue pop while empty");

endmodule
`default_nettype wire

/* hdl/stm_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module stm_div
  import stm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIV_W-1:0]     work;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_sub;
  logic                 ge;

  assign rem_sh  = {rem, work[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign ge      = (rem_sh >= {1'b0, den});

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = work;

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.num;
      rem  <= '0;
      den  <= req.den;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      work <= {work[DIV_W-2:0], ge};
      cnt  <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(DIV_W - 1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == DIV_CNT_W'(DIV_W - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy && !done)
    else $error("divider restarted while busy");

endmodule
`default_nettype wire

/* hdl/stm_back.sv */
// Back: executes queued work, runs the report arithmetic, holds the result.
`default_nettype none
module stm_back
  import stm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     q_valid,
  input  wire work_t    q_entry,
  output logic          pop,
  output div_req_t      div_req,
  input  wire div_rsp_t div_rsp,
  output logic          result_valid,
  input  wire logic     result_ready,
  output result_t       result
);

  back_state_t state, state_next;

  logic                slot_free;
  logic                load_sample;
  logic                load_report;
  logic                next_ch;
  logic [AVG_W-1:0]    savg;
  logic [SUPPLY_W-1:0] supply;
  logic                rzero;
  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] scaled;
  logic [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]   diff_neg;
  logic                neg;
  logic [DIV_W-1:0]    quot;
  logic [RESULT_W-1:0] squot;
  logic [RESULT_W-1:0] temp;
  logic [SUPPLY_W-1:0] supply_sat;

  assign slot_free = !result_valid || result_ready;
  assign diff_neg  = -diff;
  assign supply_sat = (|div_rsp.quot[DIV_W-1:SUPPLY_W]) ? '1 : div_rsp.quot[SUPPLY_W-1:0];
  assign squot = neg ? (RESULT_W'(0) - quot[RESULT_W-1:0]) : quot[RESULT_W-1:0];
  assign temp  = {{(RESULT_W-TEMP_W){cfg.temp_base[TEMP_W-1]}}, cfg.temp_base} - squot
               + {{(RESULT_W-TEMP_W){cfg.temp_offset[TEMP_W-1]}}, cfg.temp_offset};

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    load_sample = 1'b0;
    load_report = 1'b0;
    div_req     = '0;
    unique case (state)
      B_IDLE: begin
        if (q_valid && q_entry.is_report) begin
          pop = 1'b1;
          if (q_entry.ravg == '0) begin
            state_next = B_MUL;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(cfg.vdd_numerator);
            div_req.den   = DEN_W'(q_entry.ravg);
            state_next    = B_SUPPLY;
          end
        end else if (q_valid && slot_free) begin
          pop         = 1'b1;
          load_sample = 1'b1;
        end
      end
      B_SUPPLY: if (div_rsp.done) state_next = B_MUL;
      B_MUL:    state_next = B_SCALE;
      B_SCALE:  state_next = B_DIFF;
      B_DIFF:   state_next = B_ABS;
      B_ABS: begin
        if (cfg.temp_divisor == '0) begin
          state_next = B_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = diff[DIFF_W-1] ? diff_neg[DIV_W-1:0] : diff[DIV_W-1:0];
          div_req.den   = cfg.temp_divisor;
          state_next    = B_TEMP;
        end
      end
      B_TEMP: if (div_rsp.done) state_next = B_DONE;
      B_DONE: begin
        if (slot_free) begin
          load_report = 1'b1;
          state_next  = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // report datapath
  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop && q_entry.is_report) begin
      next_ch <= q_entry.next_channel;
      savg    <= q_entry.savg;
      rzero   <= (q_entry.ravg == '0);
      supply  <= '1;
    end
    if (state == B_SUPPLY && div_rsp.done) supply <= supply_sat;
    if (state == B_MUL)   prod   <= {{SUPPLY_W{1'b0}}, savg} * {{AVG_W{1'b0}}, supply};
    if (state == B_SCALE) scaled <= {7'd0, prod} * SCALED_W'(TEMP_SCALE);
    if (state == B_DIFF) begin
      diff <= {1'b0, scaled} - DIFF_W'(cfg.temp_intercept);
    end
    if (state == B_ABS) begin
      neg  <= diff[DIFF_W-1];
      quot <= '0;
    end
    if (state == B_TEMP && div_rsp.done) quot <= div_rsp.quot;
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_sample) begin
      result <= '{is_report: 1'b0, next_channel: q_entry.next_channel,
                  supply_hundredths: '0, temperature_hundredths: '0,
                  reference_zero: 1'b0};
    end else if (load_report) begin
      result <= '{is_report: 1'b1, next_channel: next_ch,
                  supply_hundredths: supply, temperature_hundredths: temp,
                  reference_zero: rzero};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_sample || load_report) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  a_zero_ref_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.reference_zero |->
      result.is_report && (result.supply_hundredths == '1))
    else $error("zero reference without saturated supply");

  a_sample_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_report |->
      (result.supply_hundredths == '0) && (result.temperature_hundredths == '0)
      && !result.reference_zero)
    else $error("sample result carries report fields");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == B_SUPPLY || state == B_TEMP) && !div_rsp.done |-> div_rsp.busy)
    else $error("waiting on an idle divider");

endmodule
`default_nettype wire

/* bench/stm_result_checker.sv */
// Checker for the supply and temperature monitor: predicts each result beat and compares it.
`timescale 1ns / 100ps
module stm_result_checker
  import stm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  item_valid,
  input  logic                  item_ready,
  input  item_t                 item,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  result_t               result,
  output int                    mismatches,
  output int                    outstanding
);

  localparam logic [VDD_NUM_W-1:0]   DEF_VDD_NUM   = 24'd148480;
  localparam logic [INTERCEPT_W-1:0] DEF_INTERCEPT = 31'd10752000;
  localparam logic [TDIV_W-1:0]      DEF_TDIV      = 16'd368;
  localparam logic [TEMP_W-1:0]      DEF_TBASE     = 16'd2500;
  localparam logic [TEMP_W-1:0]      DEF_TOFFSET   = -16'sd500;
  localparam longint                 SUPPLY_MAX    = 65535;

  // shadow of the config registers
  logic [VDD_NUM_W-1:0]     vdd_num;
  logic [INTERCEPT_W-1:0]   intercept;
  logic [TDIV_W-1:0]        tdiv;
  logic signed [TEMP_W-1:0] tbase;
  logic signed [TEMP_W-1:0] toffset;

  // shadow of the averaging state
  logic [ACC_W-1:0] ref_acc;
  logic [ACC_W-1:0] sen_acc;
  logic             on_reference;

  result_t expected_readings[$];
  int      beats_in;
  int      beats_out;

  task automatic note_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Advances the shadow state by one input beat and returns the reading it should produce.
  function automatic result_t project_reading(input item_t b);
    result_t          r;
    logic [AVG_W-1:0] ravg;
    logic [AVG_W-1:0] savg;
    longint           supply;
    longint           diff;
    longint           quot;
    longint           temp;
    r = '0;
    if (b.func == FUNC_SAMPLE) begin
      if (on_reference) begin
        ref_acc      = ref_acc + b.sample - (ref_acc >> AVG_SHIFT);
        on_reference = 1'b0;
      end else begin
        sen_acc      = sen_acc + b.sample - (sen_acc >> AVG_SHIFT);
        on_reference = 1'b1;
      end
      r.next_channel = ~on_reference;
      return r;
    end
    ravg = ref_acc[ACC_W-1:AVG_SHIFT];
    savg = sen_acc[ACC_W-1:AVG_SHIFT];
    if (ravg == '0) begin
      supply           = SUPPLY_MAX;
      r.reference_zero = 1'b1;
    end else begin
      supply = longint'(vdd_num) / longint'(ravg);
      if (supply > SUPPLY_MAX) supply = SUPPLY_MAX;
    end
    diff = longint'(savg) * supply * 100 - longint'(intercept);
    quot = (tdiv == '0) ? 0 : diff / longint'(tdiv);   // truncates toward zero
    temp = longint'(tbase) - quot + longint'(toffset);
    r.is_report              = 1'b1;
    r.next_channel           = ~on_reference;
    r.supply_hundredths      = supply[SUPPLY_W-1:0];
    r.temperature_hundredths = temp[RESULT_W-1:0];
    return r;
  endfunction

  task automatic check_reading(input result_t got);
    result_t want;
    if (expected_readings.size() == 0) begin
      note_mismatch("result beat with nothing expected");
      return;
    end
    want = expected_readings.pop_front();
    if (got.is_report !== want.is_report)
      note_mismatch($sformatf("is_report got %0b want %0b", got.is_report, want.is_report));
    if (got.next_channel !== want.next_channel)
      note_mismatch($sformatf("next_channel got %0b want %0b",
                              got.next_channel, want.next_channel));
    if (got.supply_hundredths !== want.supply_hundredths)
      note_mismatch($sformatf("supply got %0d want %0d",
                              got.supply_hundredths, want.supply_hundredths));
    if (got.temperature_hundredths !== want.temperature_hundredths)
      note_mismatch($sformatf("temperature got %0d want %0d",
                              got.temperature_hundredths, want.temperature_hundredths));
    if (got.reference_zero !== want.reference_zero)
      note_mismatch($sformatf("reference_zero got %0b want %0b",
                              got.reference_zero, want.reference_zero));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      vdd_num      = DEF_VDD_NUM;
      intercept    = DEF_INTERCEPT;
      tdiv         = DEF_TDIV;
      tbase        = DEF_TBASE;
      toffset      = DEF_TOFFSET;
      ref_acc      = '0;
      sen_acc      = '0;
      on_reference = 1'b1;
      expected_readings.delete();
      beats_in     = 0;
      beats_out    = 0;
      mismatches   = 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
          REG_VDD_NUMERATOR:  vdd_num   = pwdata[VDD_NUM_W-1:0];
          REG_TEMP_INTERCEPT: intercept = pwdata[INTERCEPT_W-1:0];
          REG_TEMP_DIVISOR:   tdiv      = pwdata[TDIV_W-1:0];
          REG_TEMP_BASE:      tbase     = pwdata[TEMP_W-1:0];
          REG_TEMP_OFFSET:    toffset   = pwdata[TEMP_W-1:0];
          default: ;
        endcase
      end
      // results first: a beat accepted at this edge cannot already have its answer out
      if (result_valid && result_ready) begin
        beats_out++;
        check_reading(result);
      end
      if (item_valid && item_ready) begin
        beats_in++;
        expected_readings.push_back(project_reading(item));
      end
      outstanding <= beats_in - beats_out;
    end
  end

endmodule

/* bench/tb_supply_and_temperature_monitor_top.sv */
// Testbench top for the supply and temperature monitor: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_supply_and_temperature_monitor_top;
  import stm_pkg::*;

  // Quiet tail; long enough for one report in flight plus margin.
  localparam int TAIL_CYCLES = 120;
  // No-idle window, in beats sent.
  localparam int STEADY_FROM = 300;
  localparam int STEADY_TO   = 450;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0] paddr        = '0;
  logic [APB_DATA_W-1:0] pwdata       = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  item_valid   = 1'b0;
  logic                  item_ready;
  item_t                 item_beat    = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result_beat;

  int mismatches;
  int outstanding;

  // steady: suppress idling on both sides (NB-driven, read at the clock edge)
  logic steady   = 1'b0;
  // channel the block will convert next; reference comes first after reset
  bit   ref_next = 1'b1;
  int   beats_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  supply_and_temperature_monitor_top uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_beat)
  );

  stm_result_checker watch (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_beat),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Result side back-pressure: ~24% stall, none inside the steady window.
  always @(posedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= 24);
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // One input beat. Random gaps before valid goes up; valid is only dropped
  // during a gap, so back-to-back beats keep it high across the edge.
  task automatic send_beat(input item_t b);
    while (!steady && $urandom_range(99) < 24) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_beat  <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (b.func == FUNC_SAMPLE) ref_next = ~ref_next;
    beats_sent++;
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] x);
    item_t b;
    b.func   = FUNC_SAMPLE;
    b.sample = x;
    send_beat(b);
  endtask

  task automatic push_report();
    item_t b;
    b.func   = FUNC_REPORT;
    b.sample = SAMPLE_W'($urandom_range(1023));   // don't-care payload, still toggled
    send_beat(b);
  endtask

  // Drop valid, wait for every expected result, then let the back end go quiet.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is tied high in the block.
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [VDD_NUM_W-1:0] num,
                                input logic [INTERCEPT_W-1:0] icpt,
                                input logic [TDIV_W-1:0] div,
                                input logic [TEMP_W-1:0] base,
                                input logic [TEMP_W-1:0] off);
    write_reg(REG_VDD_NUMERATOR, APB_DATA_W'(num));
    write_reg(REG_TEMP_INTERCEPT, APB_DATA_W'(icpt));
    write_reg(REG_TEMP_DIVISOR, APB_DATA_W'(div));
    write_reg(REG_TEMP_BASE, APB_DATA_W'(base));
    write_reg(REG_TEMP_OFFSET, APB_DATA_W'(off));
  endtask

  // Signal level for a burst; rails and near-zero show up often on purpose.
  function automatic int pick_level();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1023;
      2:       return $urandom_range(40);
      default: return $urandom_range(1023);
    endcase
  endfunction

  // Mostly well-formed traffic: bursts of samples around a per-channel level
  // (so the averages actually settle somewhere), reports sprinkled in, and a
  // little raw noise on the sample value.
  task automatic run_random(input int n);
    int    left;
    int    burst;
    int    level_ref;
    int    level_sen;
    int    v;
    item_t b;
    left  = n;
    burst = 0;
    while (left > 0) begin
      if (burst == 0) begin
        burst     = $urandom_range(60, 15);
        level_ref = pick_level();
        level_sen = pick_level();
      end
      steady <= (beats_sent >= STEADY_FROM) && (beats_sent < STEADY_TO);
      if ($urandom_range(99) < 22) begin
        push_report();
      end else begin
        b.func = FUNC_SAMPLE;
        if ($urandom_range(99) < 10) begin
          b.sample = SAMPLE_W'($urandom_range(1023));
        end else begin
          v = (ref_next ? level_ref : level_sen) + $urandom_range(32) - 16;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
          b.sample = v[SAMPLE_W-1:0];
        end
        send_beat(b);
      end
      burst--;
      left--;
    end
    steady <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening, reset register values. Channel order is ref, sensor, ref...
    push_report();            // right out of reset: reference average zero, saturated supply
    push_sample(10'd63);      // ref acc 63 -> average still zero
    push_sample(10'd1023);    // sensor
    push_report();            // zero reference with a live sensor average
    push_sample(10'd1);       // ref acc 64 -> average 1, quotient far above 16 bits
    push_sample(10'd0);
    push_report();            // saturated without the zero flag
    push_sample(10'd1023);
    push_sample(10'd1023);
    push_report();
    push_report();            // back-to-back reports, state must not move
    push_sample(10'h2AA);
    push_sample(10'h155);
    push_report();
    push_sample(10'h155);
    push_sample(10'h2AA);
    push_report();
    push_sample(10'd0);
    push_sample(10'd0);
    push_report();

    run_random(250);
    settle();

    // Upper extremes: supply saturates easily, divisor 1 makes the temperature wrap.
    apply_settings(24'hFF_FFFF, 31'h7FFF_FFFF, 16'd1, 16'h7FFF, 16'h7FFF);
    run_random(150);
    settle();

    // Lower extremes: tiny numerator, no intercept, largest divisor, most negative offsets.
    apply_settings(24'd1, 31'd0, 16'hFFFF, 16'h8000, 16'h8000);
    run_random(150);
    settle();

    // Zero divisor: quotient term drops out.
    apply_settings(VDD_NUM_W'($urandom_range(16777215, 1)),
                   INTERCEPT_W'($urandom_range(32'h7FFF_FFFF)),
                   16'd0, TEMP_W'($urandom_range(65535)), TEMP_W'($urandom_range(65535)));
    run_random(100);
    settle();

    repeat (3) begin
      apply_settings(VDD_NUM_W'($urandom_range(16777215, 1)),
                     INTERCEPT_W'($urandom_range(32'h7FFF_FFFF)),
                     TDIV_W'($urandom_range(65535, 1)), TEMP_W'($urandom_range(65535)),
                     TEMP_W'($urandom_range(65535)));
      run_random(100);
      settle();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
